>>> design/wtse_pkg.sv
// Package with shared widths, codes and reset values of the wheel tick speed estimator.
package wtse_pkg;

    // Field widths
    localparam int CIRC_W    = 14;
    localparam int GAP_W     = 10;
    localparam int TIMEOUT_W = 16;
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Scale from ms period to per-second rate
    localparam int MS_PER_S   = 1000;
    localparam int MS_PER_S_W = 10;

    // Register reset values
    localparam logic [CIRC_W-1:0]    CIRC_RESET    = CIRC_W'(2000);
    localparam logic [GAP_W-1:0]     GAP_RESET     = GAP_W'(5);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(3000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_EVAL = 1'b1;

endpackage

>>> design/wheel_tick_speed_estimator.sv
// Wheel speed estimator: debounced edge history, serial divider, linear decay extrapolation.
// Sequence: an edge transaction is absorbed while idle; an evaluate that needs no division
// goes straight to the done state, one with a period division passes through the divider,
// and one with slope extrapolation through the shared divider, then multiply and compare.
// Throughput: one transaction at a time; input ready only while the sequencer is idle.
// Reset (synchronous, active low): registers to 2000 mm / 5 ms / 3000 ms, history cleared.
module wheel_tick_speed_estimator
    import wtse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [TIME_W-1:0]    i_now_ms,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SPEED_W-1:0]   o_speed_mm_per_s
);

    localparam int CNT_W  = $clog2(SPEED_W);
    localparam int PROD_W = SPEED_W + TIMEOUT_W;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_CMP, S_DONE} t_state;
    typedef enum logic [1:0] {M_FIRST, M_PERIOD, M_SLOPE} t_mode;

    t_state r_state;
    t_mode  r_mode;

    // configuration
    logic [CIRC_W-1:0]    r_circ;
    logic [GAP_W-1:0]     r_gap;
    logic [TIMEOUT_W-1:0] r_timeout;

    // estimator state
    logic [TIME_W-1:0]  r_edge0, r_edge1;
    logic [1:0]         r_edge_cnt;
    logic [TIME_W-1:0]  r_used0, r_used1;
    logic               r_used_valid;
    logic [SPEED_W-1:0] r_cur, r_prev;

    // shared divider and multiplier datapath
    logic [SPEED_W-1:0]   r_dvd;       // dividend, shifted out; quotient shifted in
    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIMEOUT_W-1:0] r_elapsed;
    logic [PROD_W-1:0]    r_prod;

    logic [SPEED_W-1:0] r_out_speed;
    logic               r_out_valid;

    // combinational helpers
    logic [TIME_W-1:0]  w_edge_gap;
    logic               w_edge_take;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_stalled;
    logic               w_clear;
    logic [TIME_W-1:0]  w_period;
    logic [TIME_W-1:0]  w_used_dt;
    logic [SPEED_W-1:0] w_scaled;
    logic [TIME_W:0]    w_trial;
    logic               w_trial_ge;
    logic [TIME_W:0]    w_trial_sub;
    logic               w_in_fire;

    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_edge_gap  = i_now_ms - r_edge0;
    assign w_edge_take = (r_edge_cnt == 2'd0) || (w_edge_gap > TIME_W'(r_gap));
    assign w_elapsed   = i_now_ms - r_used0;
    assign w_stalled   = w_elapsed > TIME_W'(r_timeout);
    assign w_clear     = {1'b0, w_elapsed} > (33'(r_timeout) << 1);
    assign w_period    = r_edge0 - r_edge1;
    assign w_used_dt   = r_used0 - r_used1;
    // circumference * 1000 stays below 2^24 for every 14-bit value
    assign w_scaled    = SPEED_W'(r_circ) * SPEED_W'(MS_PER_S);

    // one restoring division step; a zero divisor yields all ones, the saturated speed
    assign w_trial     = {r_rem, r_dvd[SPEED_W-1]};
    assign w_trial_ge  = w_trial >= {1'b0, r_dvs};
    assign w_trial_sub = w_trial - {1'b0, r_dvs};

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_speed_mm_per_s = r_out_speed;

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_PERIOD;
            r_circ       <= CIRC_RESET;
            r_gap        <= GAP_RESET;
            r_timeout    <= TIMEOUT_RESET;
            r_edge0      <= '0;
            r_edge1      <= '0;
            r_edge_cnt   <= 2'd0;
            r_used0      <= '0;
            r_used1      <= '0;
            r_used_valid <= 1'b0;
            r_cur        <= '0;
            r_prev       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration writes; indexes past the list are dropped
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CIRC:    r_circ    <= i_cfg_data[CIRC_W-1:0];
                    CFG_GAP:     r_gap     <= i_cfg_data[GAP_W-1:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            // result register: load on completion, drop once taken
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire && (i_operation == OP_EDGE)) begin
                        // debounced edge: shift history
                        if (w_edge_take) begin
                            r_edge1 <= r_edge0;
                            r_edge0 <= i_now_ms;
                            if (r_edge_cnt != 2'd2) begin
                                r_edge_cnt <= r_edge_cnt + 2'd1;
                            end
                        end
                    end else if (w_in_fire) begin
                        r_rem     <= '0;
                        r_cnt     <= CNT_W'(SPEED_W - 1);
                        r_elapsed <= w_elapsed[TIMEOUT_W-1:0];
                        if (r_edge_cnt != 2'd2) begin
                            r_cur   <= '0;
                            r_state <= S_DONE;
                        end else if (!r_used_valid) begin
                            // first measured period
                            r_used0      <= r_edge0;
                            r_used1      <= r_edge1;
                            r_used_valid <= 1'b1;
                            r_dvd        <= w_scaled;
                            r_dvs        <= w_period;
                            r_mode       <= M_FIRST;
                            r_state      <= S_DIV;
                        end else if (r_used1 == r_edge1) begin
                            // no new edge since last measurement
                            if (w_stalled) begin
                                r_cur <= '0;
                                if (w_clear) begin
                                    r_prev     <= '0;
                                    r_edge_cnt <= 2'd1;
                                end
                                r_state <= S_DONE;
                            end else if ((r_prev > r_cur) && (w_used_dt != '0)) begin
                                r_dvd   <= r_prev - r_cur;
                                r_dvs   <= w_used_dt;
                                r_mode  <= M_SLOPE;
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            // new period measurement
                            r_used1 <= r_used0;
                            r_used0 <= r_edge0;
                            r_prev  <= r_cur;
                            r_dvd   <= w_scaled;
                            r_dvs   <= w_period;
                            r_mode  <= M_PERIOD;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_trial_ge ? w_trial_sub[TIME_W-1:0] : w_trial[TIME_W-1:0];
                    r_dvd <= {r_dvd[SPEED_W-2:0], w_trial_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        if (r_mode == M_SLOPE) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    // drop = truncated slope * elapsed ms (elapsed within timeout)
                    r_prod  <= PROD_W'(r_dvd) * PROD_W'(r_elapsed);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_prod >= PROD_W'(r_cur)) begin
                        r_cur <= '0;
                    end else begin
                        r_cur <= r_cur - r_prod[SPEED_W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_speed <= r_cur;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // period quotient written on the last divider step
            if (r_state == S_DIV && r_cnt == '0 && r_mode != M_SLOPE) begin
                r_cur <= {r_dvd[SPEED_W-2:0], w_trial_ge};
                if (r_mode == M_FIRST) begin
                    r_prev <= {r_dvd[SPEED_W-2:0], w_trial_ge};
                end
            end
        end
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the wheel tick speed estimator: directed table, then random rides.
`timescale 1ns / 1ps

module tb_top
    import wtse_pkg::*;
();

    localparam logic [SPEED_W-1:0] SPEED_SAT   = '1;
    localparam int                 QUIET_CYCLES = 40;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 SEGMENTS     = 6;
    localparam int                 SEG_ITEMS    = 150;

    // DUT connections, all inputs driven from time zero
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data       = '0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_ready;
    logic                 i_operation      = OP_EDGE;
    logic [TIME_W-1:0]    i_now_ms         = '0;
    logic                 o_out_valid;
    logic                 i_out_ready      = 1'b0;
    logic [SPEED_W-1:0]   o_speed_mm_per_s;

    wheel_tick_speed_estimator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_mm_per_s (o_speed_mm_per_s)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Estimator state mirrored by the testbench
    logic [CIRC_W-1:0]    circ_mm;
    logic [GAP_W-1:0]     gap_ms;
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic [TIME_W-1:0]    edge_t [2];
    int unsigned          edge_cnt;
    logic [TIME_W-1:0]    used_t [2];
    logic                 used_ok;
    logic [SPEED_W-1:0]   cur_speed;
    logic [SPEED_W-1:0]   prev_speed;

    logic [SPEED_W-1:0]   speed_expect_q [$];
    logic [SPEED_W-1:0]   speed_want;
    int unsigned          mismatch_cnt = 0;
    int unsigned          cycle_cnt    = 0;
    int unsigned          in_idle_pct  = 15;
    int unsigned          out_idle_pct = 78;

    // Directed table: rows with pinned set carry a hand-computed speed
    typedef struct packed {
        logic               op;
        logic [TIME_W-1:0]  now_ms;
        logic               pinned;
        logic [SPEED_W-1:0] speed;
    } t_dir_row;

    t_dir_row dir_rows [25] = '{
        '{OP_EVAL, 32'd0,          1'b1, 24'd0},  // no edges yet
        '{OP_EDGE, 32'd100,        1'b0, 24'd0},  // first edge always taken
        '{OP_EVAL, 32'd105,        1'b1, 24'd0},  // single edge only
        '{OP_EDGE, 32'd103,        1'b0, 24'd0},  // bounce, dropped
        '{OP_EDGE, 32'd105,        1'b0, 24'd0},  // exactly the gap, dropped
        '{OP_EDGE, 32'd106,        1'b0, 24'd0},
        '{OP_EVAL, 32'd110,        1'b0, 24'd0},  // first period measured
        '{OP_EDGE, 32'd200,        1'b0, 24'd0},
        '{OP_EVAL, 32'd210,        1'b0, 24'd0},  // new period, slowing
        '{OP_EVAL, 32'd250,        1'b0, 24'd0},  // decay floored at zero
        '{OP_EVAL, 32'd3201,       1'b1, 24'd0},  // past stall timeout
        '{OP_EVAL, 32'd6201,       1'b1, 24'd0},  // past twice timeout, history cleared
        '{OP_EVAL, 32'd6300,       1'b1, 24'd0},  // only one edge left
        '{OP_EDGE, 32'd6300,       1'b0, 24'd0},
        '{OP_EVAL, 32'd6300,       1'b0, 24'd0},
        '{OP_EDGE, 32'hFFFF_FFF0,  1'b0, 24'd0},
        '{OP_EVAL, 32'hFFFF_FFF8,  1'b0, 24'd0},
        '{OP_EDGE, 32'h0000_0004,  1'b0, 24'd0},  // period across the wrap
        '{OP_EVAL, 32'h0000_0005,  1'b0, 24'd0},
        '{OP_EVAL, 32'h0000_0010,  1'b0, 24'd0},  // speeding up, held
        '{OP_EDGE, 32'hFFFF_FFE0,  1'b0, 24'd0},
        '{OP_EDGE, 32'h0000_0004,  1'b0, 24'd0},  // newest edge repeats old used time
        '{OP_EVAL, 32'h0000_0005,  1'b0, 24'd0},
        '{OP_EDGE, 32'd100,        1'b0, 24'd0},
        '{OP_EVAL, 32'd110,        1'b0, 24'd0}   // equal used times, zero slope
    };

    // Speed from one edge period, truncated and saturated
    function automatic logic [SPEED_W-1:0] speed_of_period(input logic [TIME_W-1:0] newer,
                                                           input logic [TIME_W-1:0] older);
        logic [TIME_W-1:0] period;
        logic [63:0]       rate;
        period = newer - older;
        if (period == '0)
            return SPEED_SAT;
        rate = (64'(circ_mm) * 64'(MS_PER_S)) / 64'(period);
        if (rate > 64'(SPEED_SAT))
            return SPEED_SAT;
        return rate[SPEED_W-1:0];
    endfunction

    // Linear decay while slowing; slope truncated before scaling by elapsed time
    function automatic logic [SPEED_W-1:0] decayed_speed(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] since;
        logic [63:0]       slope;
        logic [63:0]       drop;
        span = used_t[0] - used_t[1];
        if (span == '0)
            return cur_speed;
        slope = (64'(prev_speed) - 64'(cur_speed)) / 64'(span);
        since = now - used_t[0];
        drop  = slope * 64'(since);
        if (drop >= 64'(cur_speed))
            return '0;
        return cur_speed - drop[SPEED_W-1:0];
    endfunction

    // Advance the mirrored state by one transaction
    task automatic model_step(input logic op, input logic [TIME_W-1:0] now,
                              output logic yields, output logic [SPEED_W-1:0] speed);
        logic [TIME_W-1:0] elapsed;
        yields = 1'b0;
        speed  = '0;
        if (op == OP_EDGE) begin
            elapsed = now - edge_t[0];
            if (edge_cnt == 0 || elapsed > gap_ms) begin
                edge_t[1] = edge_t[0];
                edge_t[0] = now;
                if (edge_cnt < 2)
                    edge_cnt++;
            end
        end else begin
            if (edge_cnt < 2) begin
                cur_speed = '0;
            end else if (!used_ok) begin
                cur_speed  = speed_of_period(edge_t[0], edge_t[1]);
                prev_speed = cur_speed;
                used_t     = edge_t;
                used_ok    = 1'b1;
            end else if (used_t[1] == edge_t[1]) begin
                // no new period since last measurement
                elapsed = now - used_t[0];
                if (elapsed > timeout_ms) begin
                    cur_speed = '0;
                    if (elapsed > {timeout_ms, 1'b0}) begin
                        prev_speed = '0;
                        if (edge_cnt > 1)
                            edge_cnt = 1;
                    end
                end else if (prev_speed > cur_speed) begin
                    cur_speed = decayed_speed(now);
                end
            end else begin
                used_t[1]  = used_t[0];
                used_t[0]  = edge_t[0];
                prev_speed = cur_speed;
                cur_speed  = speed_of_period(edge_t[0], edge_t[1]);
            end
            yields = 1'b1;
            speed  = cur_speed;
        end
    endtask

    // Entered and left at a falling edge; valid stays up for a back-to-back transaction
    task automatic send_item(input logic op, input logic [TIME_W-1:0] now,
                             input logic pinned, input logic [SPEED_W-1:0] pinned_speed);
        logic               yields;
        logic [SPEED_W-1:0] speed;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        model_step(op, now, yields, speed);
        if (yields)
            speed_expect_q.push_back(pinned ? pinned_speed : speed);
        @(negedge i_clk);
    endtask

    // Register write, only once the block has drained and settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_in_valid <= 1'b0;
        while (speed_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_CIRC:    circ_mm    = val[CIRC_W-1:0];
            CFG_GAP:     gap_ms     = val[GAP_W-1:0];
            CFG_TIMEOUT: timeout_ms = val[TIMEOUT_W-1:0];
            default:     ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side backpressure
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);

    // Compare every result transaction with the oldest expected speed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (speed_expect_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: speed %0d", o_speed_mm_per_s);
                mismatch_cnt++;
            end else begin
                speed_want = speed_expect_q.pop_front();
                if (o_speed_mm_per_s !== speed_want) begin
                    if (mismatch_cnt < 10)
                        $display("speed mismatch: expected %0d, got %0d",
                                 speed_want, o_speed_mm_per_s);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned          seg;
        int unsigned          n;
        int unsigned          pick;
        logic [TIME_W-1:0]    t;
        logic [TIME_W-1:0]    step;
        logic [TIME_W-1:0]    now;
        logic                 op;
        logic [CFG_DAT_W-1:0] circ_val;
        logic [CFG_DAT_W-1:0] gap_val;
        logic [CFG_DAT_W-1:0] timeout_val;

        // power-on state of the mirror
        circ_mm    = CIRC_RESET;
        gap_ms     = GAP_RESET;
        timeout_ms = TIMEOUT_RESET;
        edge_t     = '{'0, '0};
        used_t     = '{'0, '0};
        edge_cnt   = 0;
        used_ok    = 1'b0;
        cur_speed  = '0;
        prev_speed = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at reset register values
        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].now_ms, dir_rows[r].pinned, dir_rows[r].speed);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                in_idle_pct  = 78;
                out_idle_pct = 15;
            end else if (seg == 4) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end

            // register settings: both extremes, realistic and fully random
            case (seg)
                0: begin
                    circ_val = 16'd1;     gap_val = 16'd0;    timeout_val = 16'd1;
                end
                2: begin
                    circ_val = 16'd10000; gap_val = 16'd1000; timeout_val = 16'd65535;
                end
                3: begin
                    circ_val    = 16'($urandom_range(10000, 1));
                    gap_val     = 16'($urandom_range(20));
                    timeout_val = 16'($urandom_range(3000, 50));
                end
                4: begin
                    circ_val = 16'($urandom_range(10000, 1));
                    gap_val = 16'd5; timeout_val = 16'd3000;
                end
                default: begin
                    circ_val    = 16'($urandom_range(10000, 1));
                    gap_val     = 16'($urandom_range(1000));
                    timeout_val = 16'($urandom_range(65535, 1));
                end
            endcase
            write_reg(CFG_CIRC, circ_val);
            write_reg(CFG_GAP, gap_val);
            write_reg(CFG_TIMEOUT, timeout_val);

            // start some rides just short of the timestamp wrap
            if (seg[0])
                t = $urandom;
            else
                t = 32'hFFFF_FFFF - $urandom_range(100000);

            for (n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    // noise: arbitrary operation and time
                    op  = 1'($urandom_range(1));
                    now = $urandom;
                end else if (pick < 52) begin
                    op = OP_EDGE;
                    if ($urandom_range(9) == 0)
                        step = $urandom_range(32'(gap_ms));
                    else
                        step = 32'(gap_ms) + 1 + $urandom_range(32'(timeout_ms));
                    t   = t + step;
                    now = t;
                end else begin
                    op = OP_EVAL;
                    if ($urandom_range(5) == 0)
                        step = $urandom_range(32'(timeout_ms) * 3);
                    else
                        step = $urandom_range(32'(timeout_ms) / 3);
                    t   = t + step;
                    now = t;
                end
                send_item(op, now, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then let any stray result show up
        while (speed_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
